@@ sv/pcalu_pkg.sv @@
// Shared types, codes and microcode program of the packed instruction chain ALU.
`default_nettype none
package pcalu_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned INSTR_W = 32;
  localparam int unsigned CNT_W   = 4;   // op count and operand count, up to nine
  localparam int unsigned OW_W    = 5;   // operand width and bit position, up to sixteen
  localparam int unsigned UPC_W   = 4;

  // Operator codes
  localparam logic [1:0] OP_ADD = 2'b00;
  localparam logic [1:0] OP_SUB = 2'b01;
  localparam logic [1:0] OP_MUL = 2'b10;
  localparam logic [1:0] OP_DIV = 2'b11;

  // Command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_OPERAND = 1'b1;

  // Step addresses of the microprogram
  localparam logic [UPC_W-1:0] S_WAIT   = 4'd0;
  localparam logic [UPC_W-1:0] S_SCAN   = 4'd1;
  localparam logic [UPC_W-1:0] S_FETCH  = 4'd2;
  localparam logic [UPC_W-1:0] S_DISP   = 4'd3;
  localparam logic [UPC_W-1:0] S_DIVI   = 4'd4;
  localparam logic [UPC_W-1:0] S_DIVS   = 4'd5;
  localparam logic [UPC_W-1:0] S_DIVW   = 4'd6;
  localparam logic [UPC_W-1:0] S_ALU    = 4'd7;
  localparam logic [UPC_W-1:0] S_LOADF  = 4'd8;
  localparam logic [UPC_W-1:0] S_FINISH = 4'd9;
  localparam logic [UPC_W-1:0] S_EMIT   = 4'd10;
  localparam logic [UPC_W-1:0] S_BACK   = 4'd11;

  typedef enum logic [3:0] {
    DP_NOP        = 4'd0,
    DP_ACCEPT     = 4'd1,
    DP_EXTRACT    = 4'd2,
    DP_DIV_INIT   = 4'd3,
    DP_DIV_STEP   = 4'd4,
    DP_DIV_WB     = 4'd5,
    DP_ALU_WB     = 4'd6,
    DP_LOAD_FIRST = 4'd7,
    DP_EMIT       = 4'd8
  } dp_op_e;

  typedef enum logic [3:0] {
    C_ALWAYS    = 4'd0,
    C_NO_WORK   = 4'd1,
    C_NO_MORE   = 4'd2,
    C_FIRST     = 4'd3,
    C_NOT_DIV   = 4'd4,
    C_OPND_ZERO = 4'd5,
    C_DIV_MORE  = 4'd6,
    C_NOT_DONE  = 4'd7,
    C_OUT_FULL  = 4'd8
  } cond_e;

  typedef struct packed {
    dp_op_e           dp_op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic no_work;
    logic no_more;
    logic first;
    logic not_div;
    logic opnd_zero;
    logic div_more;
    logic not_done;
    logic out_full;
  } status_t;

  // Control store: jump to target when the condition holds, else fall through.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t uw;
    case (upc)
      S_WAIT:   uw = '{dp_op: DP_ACCEPT,     cond: C_NO_WORK,   target: S_WAIT};
      S_SCAN:   uw = '{dp_op: DP_NOP,        cond: C_NO_MORE,   target: S_FINISH};
      S_FETCH:  uw = '{dp_op: DP_EXTRACT,    cond: C_FIRST,     target: S_LOADF};
      S_DISP:   uw = '{dp_op: DP_NOP,        cond: C_NOT_DIV,   target: S_ALU};
      S_DIVI:   uw = '{dp_op: DP_DIV_INIT,   cond: C_OPND_ZERO, target: S_SCAN};
      S_DIVS:   uw = '{dp_op: DP_DIV_STEP,   cond: C_DIV_MORE,  target: S_DIVS};
      S_DIVW:   uw = '{dp_op: DP_DIV_WB,     cond: C_ALWAYS,    target: S_SCAN};
      S_ALU:    uw = '{dp_op: DP_ALU_WB,     cond: C_ALWAYS,    target: S_SCAN};
      S_LOADF:  uw = '{dp_op: DP_LOAD_FIRST, cond: C_ALWAYS,    target: S_SCAN};
      S_FINISH: uw = '{dp_op: DP_NOP,        cond: C_NOT_DONE,  target: S_WAIT};
      S_EMIT:   uw = '{dp_op: DP_EMIT,       cond: C_OUT_FULL,  target: S_EMIT};
      S_BACK:   uw = '{dp_op: DP_NOP,        cond: C_ALWAYS,    target: S_WAIT};
      default:  uw = '{dp_op: DP_NOP,        cond: C_ALWAYS,    target: S_WAIT};
    endcase
    return uw;
  endfunction

endpackage
`default_nettype wire

@@ sv/pcalu_seq.sv @@
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module pcalu_seq (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire pcalu_pkg::status_t              status_i,
  output pcalu_pkg::ucode_t                    ctrl_o
);

  logic [pcalu_pkg::UPC_W-1:0] upc_q, upc_d;
  pcalu_pkg::ucode_t uw;
  logic take;

  always_comb begin
    uw = pcalu_pkg::ucode_rom(upc_q);
    case (uw.cond)
      pcalu_pkg::C_ALWAYS:    take = 1'b1;
      pcalu_pkg::C_NO_WORK:   take = status_i.no_work;
      pcalu_pkg::C_NO_MORE:   take = status_i.no_more;
      pcalu_pkg::C_FIRST:     take = status_i.first;
      pcalu_pkg::C_NOT_DIV:   take = status_i.not_div;
      pcalu_pkg::C_OPND_ZERO: take = status_i.opnd_zero;
      pcalu_pkg::C_DIV_MORE:  take = status_i.div_more;
      pcalu_pkg::C_NOT_DONE:  take = status_i.not_done;
      pcalu_pkg::C_OUT_FULL:  take = status_i.out_full;
      default:                take = 1'b1;
    endcase
    upc_d = take ? uw.target : upc_q + 1'b1;
  end

  assign ctrl_o = uw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= pcalu_pkg::S_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

  // The step counter never runs past the last program step
  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= pcalu_pkg::S_BACK)
    else $error("step counter outside the program");

  // The divide loop only ends by falling through to the write-back step
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == pcalu_pkg::S_DIVS) && !status_i.div_more |=> upc_q == pcalu_pkg::S_DIVW)
    else $error("divide loop left early");

  // The wait step is only left when an operand word for an active chain is offered
  a_wait_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == pcalu_pkg::S_WAIT) && status_i.no_work |=> upc_q == pcalu_pkg::S_WAIT)
    else $error("left wait step without work");

endmodule
`default_nettype wire

@@ sv/pcalu_div.sv @@
// Restoring divider: unsigned 32 by 16 bits, one quotient bit per cycle while step_i is high.
`default_nettype none
module pcalu_div (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  input  wire                                 step_i,
  input  wire [pcalu_pkg::ACC_W-1:0]          dividend_i,
  input  wire [pcalu_pkg::WORD_W-1:0]         divisor_i,
  output logic [pcalu_pkg::ACC_W-1:0]         quotient_o,
  output logic                                last_o
);

  localparam int unsigned CW = $clog2(pcalu_pkg::ACC_W);

  logic [pcalu_pkg::ACC_W-1:0]  quo_q;
  logic [pcalu_pkg::WORD_W-1:0] rem_q;
  logic [CW-1:0]                cnt_q;
  logic [pcalu_pkg::WORD_W:0]   rem_sh;
  logic [pcalu_pkg::WORD_W:0]   rem_sub;
  logic                         ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[pcalu_pkg::ACC_W-1]};
    ge      = rem_sh >= {1'b0, divisor_i};
    rem_sub = rem_sh - {1'b0, divisor_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (step_i) begin
      quo_q <= {quo_q[pcalu_pkg::ACC_W-2:0], ge};
      rem_q <= ge ? rem_sub[pcalu_pkg::WORD_W-1:0] : rem_sh[pcalu_pkg::WORD_W-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = (cnt_q == CW'(pcalu_pkg::ACC_W - 1));

endmodule
`default_nettype wire

@@ sv/pcalu_dp.sv @@
// Datapath: decode store, operand unpacking, accumulator, ALU and result register.
`default_nettype none
module pcalu_dp #(
  parameter int unsigned MAX_OPS = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire pcalu_pkg::ucode_t               ctrl_i,
  output pcalu_pkg::status_t                   status_o,
  input  wire                                  in_valid_i,
  input  wire                                  command_i,
  input  wire [pcalu_pkg::INSTR_W-1:0]         instruction_i,
  input  wire [pcalu_pkg::WORD_W-1:0]          operand_word_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [pcalu_pkg::ACC_W-1:0]   value_o,
  output logic                                 div_by_zero_o
);

  localparam int unsigned IDX_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
  localparam logic [pcalu_pkg::CNT_W-1:0] TOTAL_MAX = pcalu_pkg::CNT_W'(MAX_OPS);
  localparam logic [pcalu_pkg::OW_W-1:0]  WORD_POS  = pcalu_pkg::OW_W'(pcalu_pkg::WORD_W);

  logic [1:0]                      ops_q [MAX_OPS];
  logic [pcalu_pkg::CNT_W-1:0]     total_q;
  logic [pcalu_pkg::OW_W-1:0]      width_q;
  logic [pcalu_pkg::CNT_W-1:0]     taken_q;
  logic [pcalu_pkg::ACC_W-1:0]     acc_q;
  logic                            err_q;
  logic                            active_q;
  logic [pcalu_pkg::WORD_W-1:0]    word_q;
  logic [pcalu_pkg::OW_W-1:0]      pos_q;
  logic [pcalu_pkg::WORD_W-1:0]    opnd_q;
  logic [1:0]                      code_q;
  logic                            neg_q;
  logic                            out_valid_q;
  logic [pcalu_pkg::ACC_W-1:0]     out_value_q;
  logic                            out_dbz_q;

  logic                            accept;
  logic [pcalu_pkg::CNT_W-1:0]     count;
  logic [pcalu_pkg::OW_W-1:0]      wf_shamt;
  logic [pcalu_pkg::INSTR_W-1:0]   wf_shifted;
  logic [1:0]                      ops_d [MAX_OPS];
  logic [pcalu_pkg::OW_W:0]        needed;
  logic [pcalu_pkg::OW_W-1:0]      pos_next;
  logic [pcalu_pkg::WORD_W:0]      mask;
  logic [pcalu_pkg::WORD_W-1:0]    word_sh;
  logic [pcalu_pkg::CNT_W-1:0]     idx_full;
  logic [pcalu_pkg::ACC_W+pcalu_pkg::WORD_W-1:0] prod;
  logic [pcalu_pkg::ACC_W-1:0]     alu_res;
  logic [pcalu_pkg::ACC_W-1:0]     acc_mag;
  logic [pcalu_pkg::ACC_W-1:0]     quot;
  logic                            div_last;
  logic                            out_full;

  assign accept = in_valid_i && (ctrl_i.dp_op == pcalu_pkg::DP_ACCEPT);

  // Instruction decode
  always_comb begin
    count      = {1'b0, instruction_i[31:29]} + 1'b1;
    wf_shamt   = 5'd25 - {count, 1'b0};
    wf_shifted = instruction_i >> wf_shamt;
    for (int i = 0; i < MAX_OPS; i++) begin
      ops_d[i] = (i < int'(count)) ? instruction_i[27-2*i +: 2] : pcalu_pkg::OP_ADD;
    end
  end

  always_comb begin
    needed   = {2'b00, total_q} + 1'b1;
    pos_next = pos_q - width_q;
    mask     = ({{pcalu_pkg::WORD_W{1'b0}}, 1'b1} << width_q) - 1'b1;
    word_sh  = word_q >> pos_next;
    idx_full = taken_q - 1'b1;
    prod     = acc_q * opnd_q;
    case (code_q)
      pcalu_pkg::OP_ADD: alu_res = acc_q + {16'd0, opnd_q};
      pcalu_pkg::OP_SUB: alu_res = acc_q - {16'd0, opnd_q};
      pcalu_pkg::OP_MUL: alu_res = prod[pcalu_pkg::ACC_W-1:0];
      default:           alu_res = acc_q;
    endcase
    acc_mag  = acc_q[pcalu_pkg::ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
    out_full = out_valid_q && !out_ready_i;
  end

  pcalu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.dp_op == pcalu_pkg::DP_DIV_INIT),
    .step_i     (ctrl_i.dp_op == pcalu_pkg::DP_DIV_STEP),
    .dividend_i (acc_mag),
    .divisor_i  (opnd_q),
    .quotient_o (quot),
    .last_o     (div_last)
  );

  always_comb begin
    status_o.no_work   = !(in_valid_i && (command_i == pcalu_pkg::CMD_OPERAND) && active_q);
    status_o.no_more   = (pos_q < width_q) || ({2'b00, taken_q} >= needed);
    status_o.first     = (taken_q == '0);
    status_o.not_div   = (code_q != pcalu_pkg::OP_DIV);
    status_o.opnd_zero = (opnd_q == '0);
    status_o.div_more  = !div_last;
    status_o.not_done  = ({2'b00, taken_q} < needed);
    status_o.out_full  = out_full;
  end

  // Output valid: set on emit, drop once the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctrl_i.dp_op == pcalu_pkg::DP_EMIT) && !out_full) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_OPS; i++) begin
        ops_q[i] <= pcalu_pkg::OP_ADD;
      end
      total_q     <= '0;
      width_q     <= 5'd1;
      taken_q     <= '0;
      acc_q       <= '0;
      err_q       <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      case (ctrl_i.dp_op)
        pcalu_pkg::DP_ACCEPT: begin
          if (accept && (command_i == pcalu_pkg::CMD_LOAD)) begin
            for (int i = 0; i < MAX_OPS; i++) begin
              ops_q[i] <= ops_d[i];
            end
            total_q  <= (count > TOTAL_MAX) ? TOTAL_MAX : count;
            width_q  <= {1'b0, wf_shifted[3:0]} + 1'b1;
            taken_q  <= '0;
            acc_q    <= '0;
            err_q    <= 1'b0;
            active_q <= 1'b1;
          end
        end
        pcalu_pkg::DP_DIV_INIT: begin
          // Zero divisor: flag it, keep the accumulator, count the operand
          if (opnd_q == '0) begin
            err_q   <= 1'b1;
            taken_q <= taken_q + 1'b1;
          end
        end
        pcalu_pkg::DP_DIV_WB: begin
          acc_q   <= neg_q ? (~quot + 1'b1) : quot;
          taken_q <= taken_q + 1'b1;
        end
        pcalu_pkg::DP_ALU_WB: begin
          acc_q   <= alu_res;
          taken_q <= taken_q + 1'b1;
        end
        pcalu_pkg::DP_LOAD_FIRST: begin
          acc_q   <= {16'd0, opnd_q};
          taken_q <= taken_q + 1'b1;
        end
        pcalu_pkg::DP_EMIT: begin
          if (!out_full) begin
            active_q    <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.dp_op)
      pcalu_pkg::DP_ACCEPT: begin
        if (accept && (command_i == pcalu_pkg::CMD_OPERAND)) begin
          word_q <= operand_word_i;
          pos_q  <= WORD_POS;
        end
      end
      pcalu_pkg::DP_EXTRACT: begin
        pos_q  <= pos_next;
        opnd_q <= word_sh & mask[pcalu_pkg::WORD_W-1:0];
        code_q <= ops_q[idx_full[IDX_W-1:0]];
      end
      pcalu_pkg::DP_DIV_INIT: begin
        neg_q <= acc_q[pcalu_pkg::ACC_W-1];
      end
      pcalu_pkg::DP_EMIT: begin
        if (!out_full) begin
          out_value_q <= err_q ? '0 : acc_q;
          out_dbz_q   <= err_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = out_value_q;
  assign div_by_zero_o = out_dbz_q;

  a_alu_not_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.dp_op == pcalu_pkg::DP_ALU_WB |-> code_q != pcalu_pkg::OP_DIV)
    else $error("divide code routed to the ALU step");

  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_dbz_q |-> out_value_q == '0)
    else $error("flagged result carries a non-zero value");

  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {2'b00, taken_q} <= needed)
    else $error("more operands taken than the chain needs");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q != '0) && (width_q <= WORD_POS))
    else $error("operand width out of range");

endmodule
`default_nettype wire

@@ sv/packed_instruction_chain_alu.sv @@
// Packed instruction chain ALU top level: microcode sequencer driving the datapath.
// Load transaction: taken in the wait step, no result. Operand word: accepted in wait, then
// each operand is extracted; the first is loaded, later ones folded by add, subtract, multiply
// or divide (32-step bit-serial divider loop, skipped on zero divisor); finish closes the word.
// After the last fold: scan, finish, emit; emit sets result valid once the output has room.
// Reset (asynchronous, active low) returns the sequencer to wait and empties the chain.
`default_nettype none
module packed_instruction_chain_alu #(
  parameter int unsigned MAX_OPS = 8
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 command_i,
  input  wire [pcalu_pkg::INSTR_W-1:0]        instruction_i,
  input  wire [pcalu_pkg::WORD_W-1:0]         operand_word_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [pcalu_pkg::ACC_W-1:0]  value_o,
  output logic                                div_by_zero_o
);

  pcalu_pkg::ucode_t  ctrl;
  pcalu_pkg::status_t status;

  pcalu_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  pcalu_dp #(
    .MAX_OPS (MAX_OPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .in_valid_i     (in_valid_i),
    .command_i      (command_i),
    .instruction_i  (instruction_i),
    .operand_word_i (operand_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_o        (value_o),
    .div_by_zero_o  (div_by_zero_o)
  );

  assign in_ready_o = (ctrl.dp_op == pcalu_pkg::DP_ACCEPT);

endmodule
`default_nettype wire
